@@ sv/sorted_table_insert_delete_macros.svh @@
// Assertion helpers for the checker file.
`ifndef SORTED_TABLE_INSERT_DELETE_MACROS_SVH
`define SORTED_TABLE_INSERT_DELETE_MACROS_SVH

// Clocked check, muted while reset is asserted.
`define STID_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define STID_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/stid_pkg.sv @@
package stid_pkg;

	localparam int CAPACITY_DEF = 16;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_INSERTED  = 2'd0;
	localparam status_t STATUS_DELETED   = 2'd1;
	localparam status_t STATUS_NOT_FOUND = 2'd2;
	localparam status_t STATUS_FULL      = 2'd3;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_DELETE = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		status_t    status;
		logic [4:0] entry_count;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_SCAN,
		ST_DEL,
		ST_REPORT
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_START_INS,
		OP_START_DEL,
		OP_INS_MOVE,
		OP_INS_PLACE,
		OP_SCAN_NEXT,
		OP_SCAN_HIT,
		OP_DEL_MOVE
	} op_t;

	typedef struct packed {
		op_t     op;
		logic    rec;     // latch status code
		status_t status;
		logic    fin;     // commit count and load result register
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic gt;
		logic eq;
		logic idx_zero;
		logic scan_more;
		logic del_more;
		logic out_busy;
	} flags_t;

endpackage

@@ sv/sorted_table_insert_delete.sv @@
// Sorted table of signed 32-bit keys, ascending, duplicates allowed, up to CAPACITY
// entries in a single-port-write, registered-read memory. Insert (req_type 0) walks
// down from the tail moving larger keys up one slot, and drops the key after any equal
// copies; delete (req_type 1) scans up from the head for one copy and closes the gap.
// Every transaction returns one result: status and the entry count afterwards (mod 32).
// The memory moves one entry per cycle: an insert steps past every key greater than the
// new one, a delete steps through every entry held whether found or not, and refused
// inserts and deletes on an empty table go straight to the report step. The next
// transaction is taken in the cycle after the result is loaded. One transaction is
// in flight at a time; a new one is taken while the previous result still waits in
// the output register, and the block only stalls in its report step while that
// result is unread. Memory contents need no clearing after reset.
module sorted_table_insert_delete #(
	parameter int CAPACITY = stid_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  stid_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output stid_pkg::out_t out_data
);
	import stid_pkg::*;

	cmd_t   cmd;
	flags_t flags;

	stid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (in_data.req_type),
		.in_ready (in_ready),
		.flags    (flags),
		.cmd      (cmd)
	);

	stid_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.flags     (flags),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

@@ sv/stid_ctrl.sv @@
module stid_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             req_type,
	output logic             in_ready,
	input  stid_pkg::flags_t flags,
	output stid_pkg::cmd_t   cmd
);
	import stid_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.op     = OP_NONE;
		cmd.rec    = 1'b0;
		cmd.status = STATUS_INSERTED;
		cmd.fin    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (req_type == REQ_INSERT) begin
						if (flags.full) begin
							cmd.rec    = 1'b1;
							cmd.status = STATUS_FULL;
							state_d    = ST_REPORT;
						end else begin
							cmd.op  = OP_START_INS;
							state_d = ST_INS;
						end
					end else begin
						if (flags.empty) begin
							cmd.rec    = 1'b1;
							cmd.status = STATUS_NOT_FOUND;
							state_d    = ST_REPORT;
						end else begin
							cmd.op  = OP_START_DEL;
							state_d = ST_SCAN;
						end
					end
				end
			end
			// walk down from the tail, moving larger entries up one slot
			ST_INS: begin
				if (flags.idx_zero || !flags.gt) begin
					cmd.op     = OP_INS_PLACE;
					cmd.rec    = 1'b1;
					cmd.status = STATUS_INSERTED;
					state_d    = ST_REPORT;
				end else begin
					cmd.op = OP_INS_MOVE;
				end
			end
			ST_SCAN: begin
				if (flags.eq) begin
					if (flags.scan_more) begin
						cmd.op  = OP_SCAN_HIT;
						state_d = ST_DEL;
					end else begin
						cmd.rec    = 1'b1;
						cmd.status = STATUS_DELETED;
						state_d    = ST_REPORT;
					end
				end else if (flags.scan_more) begin
					cmd.op = OP_SCAN_NEXT;
				end else begin
					cmd.rec    = 1'b1;
					cmd.status = STATUS_NOT_FOUND;
					state_d    = ST_REPORT;
				end
			end
			// close the gap: entry k takes entry k+1
			ST_DEL: begin
				cmd.op = OP_DEL_MOVE;
				if (!flags.del_more) begin
					cmd.rec    = 1'b1;
					cmd.status = STATUS_DELETED;
					state_d    = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (!flags.out_busy) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ sv/stid_dp.sv @@
module stid_dp #(
	parameter int CAPACITY = stid_pkg::CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  stid_pkg::in_t    in_data,
	input  stid_pkg::cmd_t   cmd,
	output stid_pkg::flags_t flags,
	input  logic             out_ready,
	output logic             out_valid,
	output stid_pkg::out_t   out_data
);
	import stid_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = CW + 1;

	logic [31:0]        mem [CAPACITY];
	logic [31:0]        rdata_q;
	logic signed [31:0] val_q;
	logic [AW-1:0]      idx_q, idx_d, rd_addr;
	logic               we;
	logic [31:0]        wdata;
	logic [CW-1:0]      count_q, count_nxt;
	status_t            status_q;
	logic               out_valid_q;
	out_t               out_q;
	logic [XW-1:0]      idx_x, count_x;

	assign idx_x   = XW'(idx_q);
	assign count_x = XW'(count_q);

	// The read issued this cycle is always the entry the next step looks at.
	always_comb begin
		idx_d   = idx_q;
		rd_addr = idx_q + AW'(1);
		we      = 1'b0;
		wdata   = val_q;
		case (cmd.op)
			OP_START_INS: begin
				idx_d   = AW'(count_q);
				rd_addr = AW'(count_q - CW'(1));
			end
			OP_START_DEL: begin
				idx_d   = '0;
				rd_addr = '0;
			end
			OP_INS_MOVE: begin
				we      = 1'b1;
				wdata   = rdata_q;
				idx_d   = idx_q - AW'(1);
				rd_addr = idx_q - AW'(2);
			end
			OP_INS_PLACE: begin
				we = 1'b1;
			end
			OP_SCAN_NEXT: begin
				idx_d = idx_q + AW'(1);
			end
			OP_DEL_MOVE: begin
				we      = 1'b1;
				wdata   = rdata_q;
				idx_d   = idx_q + AW'(1);
				rd_addr = idx_q + AW'(2);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[idx_q] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_START_INS || cmd.op == OP_START_DEL) begin
			val_q <= in_data.value;
		end
		if (cmd.rec) begin
			status_q <= cmd.status;
		end
		if (cmd.fin) begin
			out_q.status      <= status_q;
			out_q.entry_count <= 5'(count_nxt);
		end
	end

	always_comb begin
		case (status_q)
			STATUS_INSERTED: count_nxt = count_q + CW'(1);
			STATUS_DELETED:  count_nxt = count_q - CW'(1);
			default:         count_nxt = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (cmd.fin) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign flags.full      = (count_q == CW'(CAPACITY));
	assign flags.empty     = (count_q == '0);
	assign flags.gt        = ($signed(rdata_q) > val_q);
	assign flags.eq        = (rdata_q == val_q);
	assign flags.idx_zero  = (idx_q == '0);
	assign flags.scan_more = ((idx_x + XW'(1)) < count_x);
	assign flags.del_more  = ((idx_x + XW'(2)) < count_x);
	assign flags.out_busy  = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ sv/stid_chk.sv @@
`include "sorted_table_insert_delete_macros.svh"

module stid_chk #(
	parameter int CAPACITY = stid_pkg::CAPACITY_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input stid_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_ready,
	input stid_pkg::out_t out_data
);
	import stid_pkg::*;

	`STID_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
	`STID_ASSERT(a_one_in_flight, in_valid && in_ready |=> !in_ready, "second transaction taken while busy")
	`STID_ASSERT(a_full_count, out_valid && out_data.status == STATUS_FULL |-> out_data.entry_count == 5'(CAPACITY), "full status with wrong count")
	`STID_ASSERT(a_count_bound, out_valid |-> (CAPACITY > 31) || (out_data.entry_count <= 5'(CAPACITY)), "entry count above capacity")
	// out_valid is cleared asynchronously by reset, so this check holds while reset is asserted
	`STID_ASSERT_RST(a_reset_quiet, !arst_n |=> !out_valid, "result valid during reset")

endmodule

bind sorted_table_insert_delete stid_chk #(.CAPACITY(CAPACITY)) u_stid_chk (.*);
